[rtl/yb24_pkg.sv]
`timescale 1ns / 1ps

package yb24_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int DIM_W     = CFG_W;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int IDX_W     = 24;
    localparam int PROD_W    = ROW_W + DIM_W;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // x/100 for x < 2^15 is (x * 5243) >> 19, exact for our range
    localparam int RECIP_100 = 5243;
    localparam int RECIP_SH  = 19;
    localparam int KMUL_W    = 20;
    localparam logic [KMUL_W-1:0] K_RED   = KMUL_W'(140 * RECIP_100);
    localparam logic [KMUL_W-1:0] K_G_U   = KMUL_W'(34 * RECIP_100);
    localparam logic [KMUL_W-1:0] K_G_V   = KMUL_W'(71 * RECIP_100);
    localparam logic [KMUL_W-1:0] K_BLUE  = KMUL_W'(177 * RECIP_100);
    localparam int TERM_W = 9;     // signed, |term| <= 226
    localparam int SUM_W  = 11;    // signed lane sum

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_inv;
        logic [COL_W-1:0] col;
        logic [DIM_W-1:0] width;
        logic             frame_end;
    } addr_info_t;

    // trunc-toward-zero of coef*(c-128)/100, coef folded into k
    function automatic logic signed [TERM_W-1:0] chroma_term(
        input logic [PIX_W-1:0]  c,
        input logic [KMUL_W-1:0] k
    );
        logic                    neg;
        logic [PIX_W-1:0]        mag;
        logic [PIX_W+KMUL_W-1:0] prod;
        logic [TERM_W-1:0]       q;
        neg  = ~c[PIX_W-1];
        mag  = neg ? (PIX_W'(1 << (PIX_W - 1)) - {1'b0, c[PIX_W-2:0]})
                   : {1'b0, c[PIX_W-2:0]};
        prod = (PIX_W + KMUL_W)'(mag) * (PIX_W + KMUL_W)'(k);
        q    = prod[RECIP_SH +: TERM_W];
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v < 0)
            res = '0;
        else if (v > $signed(SUM_W'(255)))
            res = '1;
        else
            res = v[PIX_W-1:0];
        return res;
    endfunction

endpackage

[rtl/yb24_if.sv]
`timescale 1ns / 1ps

interface yb24_in_if;
    import yb24_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;

    modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                    input ready);
    modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                  output ready);
endinterface

interface yb24_out_if;
    import yb24_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] blue_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] red_second;
    logic [IDX_W-1:0] pixel_index;
    logic             frame_end;

    modport source (output valid, blue_first, green_first, red_first, blue_second,
                    green_second, red_second, pixel_index, frame_end,
                    input ready);
    modport sink (input valid, blue_first, green_first, red_first, blue_second,
                  green_second, red_second, pixel_index, frame_end,
                  output ready);
endinterface

[rtl/yb24_pixel_lane.sv]
`timescale 1ns / 1ps

// one pixel: luma plus shared chroma terms, clamped
module yb24_pixel_lane
    import yb24_pkg::*;
(
    input  logic [PIX_W-1:0]         luma,
    input  logic signed [TERM_W-1:0] term_b,
    input  logic signed [TERM_W-1:0] term_gu,
    input  logic signed [TERM_W-1:0] term_gv,
    input  logic signed [TERM_W-1:0] term_r,
    output logic [PIX_W-1:0]         blue,
    output logic [PIX_W-1:0]         green,
    output logic [PIX_W-1:0]         red
);

    logic signed [SUM_W-1:0] y_s;
    logic signed [SUM_W-1:0] sum_b;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_r;

    assign y_s   = $signed({{(SUM_W - PIX_W){1'b0}}, luma});
    assign sum_b = y_s + SUM_W'(term_b);
    assign sum_g = y_s - SUM_W'(term_gu) - SUM_W'(term_gv);
    assign sum_r = y_s + SUM_W'(term_r);

    assign blue  = clamp_pix(sum_b);
    assign green = clamp_pix(sum_g);
    assign red   = clamp_pix(sum_r);

endmodule

[rtl/yb24_addr_gen.sv]
`timescale 1ns / 1ps

// frame size registers and column/row counters
module yb24_addr_gen
    import yb24_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 advance,
    output addr_info_t           info
);

    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] width_cfg_next;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [CFG_W-1:0] height_cfg_next;
    logic [COL_W-1:0] column_count_reg;
    logic [COL_W-1:0] column_count_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] col_lim;
    logic [DIM_W-1:0] row_lim;
    logic [DIM_W-1:0] col_c;
    logic [DIM_W-1:0] row_c;
    logic             line_end;
    logic             frame_end;

    always_comb
    begin
        if (width_cfg_reg < DIM_W'(2))
            w_eff = DIM_W'(2);
        else if (width_cfg_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_cfg_reg;
        w_eff[0] = 1'b0;

        if (height_cfg_reg < DIM_W'(1))
            h_eff = DIM_W'(1);
        else if (height_cfg_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_cfg_reg;
    end

    // counters past a shrunk frame are pinned to the last pair / line
    assign col_lim   = w_eff - DIM_W'(2);
    assign row_lim   = h_eff - DIM_W'(1);
    assign col_c     = (DIM_W'(column_count_reg) > col_lim) ? col_lim
                                                            : DIM_W'(column_count_reg);
    assign row_c     = (DIM_W'(row_count_reg) > row_lim) ? row_lim : DIM_W'(row_count_reg);
    assign line_end  = (col_c + DIM_W'(2)) >= w_eff;
    assign frame_end = line_end && ((row_c + DIM_W'(1)) >= h_eff);

    assign info.row_inv   = ROW_W'(row_lim - row_c);
    assign info.col       = COL_W'(col_c);
    assign info.width     = w_eff;
    assign info.frame_end = frame_end;

    always_comb
    begin
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  width_cfg_next  = cfg_data;
                REG_FRAME_HEIGHT: height_cfg_next = cfg_data;
                default:          ;
            endcase
        end

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (advance)
        begin
            if (line_end)
            begin
                column_count_next = '0;
                row_count_next    = frame_end ? '0 : ROW_W'(row_c + DIM_W'(1));
            end
            else
            begin
                column_count_next = COL_W'(col_c + DIM_W'(2));
                row_count_next    = ROW_W'(row_c);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg    <= WIDTH_RESET;
            height_cfg_reg   <= HEIGHT_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            width_cfg_reg    <= width_cfg_next;
            height_cfg_reg   <= height_cfg_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

`ifndef NO_ASSERTIONS
    // pairs always start on an even column
    a_col_even: assert property (@(posedge clk) disable iff (!rst_n)
        column_count_reg[0] == 1'b0)
        else $error("column counter odd");

    // frame end returns both counters to origin
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_end |=> column_count_reg == '0 && row_count_reg == '0)
        else $error("counters did not wrap at frame end");
`endif

endmodule

[rtl/yuyv_to_bgr24_flipped_unit.sv]
`timescale 1ns / 1ps

// YUYV to BGR24 converter with bottom-up addressing. Each request on yuyv
// carries one macropixel (Y0, U, Y1, V) and yields one request on bgr with
// two clamped B,G,R pixels sharing the chroma, the bottom-up index of the
// first pixel, (height-1-row)*width + col (byte offset is 3x that), and a
// frame_end flag on the last pair of the frame. Throughput is one pair per
// clock. Each pair passes the stage 1 registers and then the output register
// before bgr.valid rises. Stage 1 forms the four chroma terms (constant
// multiply by coef/100 reciprocal) and latches the clamped counter position;
// stage 2 runs two pixel lanes plus the index multiply-add and holds the
// output register. Either stage refills as soon as its content moves on, so
// a full pipeline stalls only while bgr.ready is low. Frame size is set
// through cfg_we/cfg_index/cfg_data (0 = width, 1 = height); the user must
// write it only while no request is in flight, which the block does not
// enforce; width is saturated to 2..4096 and forced even, height to 1..4096.
module yuyv_to_bgr24_flipped_unit
    import yb24_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    yb24_in_if.sink              yuyv,
    yb24_out_if.source           bgr,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // pipeline handshake
    logic s1_ready;
    logic s2_ready;
    logic in_accept;

    // stage 1: terms and position
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [PIX_W-1:0]         s1_luma0_reg;
    logic [PIX_W-1:0]         s1_luma1_reg;
    logic signed [TERM_W-1:0] s1_tb_reg;
    logic signed [TERM_W-1:0] s1_tgu_reg;
    logic signed [TERM_W-1:0] s1_tgv_reg;
    logic signed [TERM_W-1:0] s1_tr_reg;
    addr_info_t               s1_addr_reg;
    addr_info_t               addr_now;

    // stage 2: output register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PIX_W-1:0] b0_reg, g0_reg, r0_reg;
    logic [PIX_W-1:0] b1_reg, g1_reg, r1_reg;
    logic [IDX_W-1:0] index_reg;
    logic             frame_end_reg;

    // lane results
    logic [PIX_W-1:0] b0, g0, r0;
    logic [PIX_W-1:0] b1, g1, r1;
    logic [PROD_W-1:0] row_base;
    logic [PROD_W-1:0] index_full;

    assign s2_ready   = !out_valid_reg || bgr.ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign yuyv.ready = s1_ready;
    assign in_accept  = yuyv.valid && s1_ready;

    yb24_addr_gen u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_accept),
        .info      (addr_now)
    );

    assign s1_valid_next  = s1_ready ? yuyv.valid : s1_valid_reg;
    assign out_valid_next = s2_ready ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_luma0_reg <= yuyv.luma_first;
            s1_luma1_reg <= yuyv.luma_second;
            s1_tb_reg    <= chroma_term(yuyv.chroma_blue, K_BLUE);
            s1_tgu_reg   <= chroma_term(yuyv.chroma_blue, K_G_U);
            s1_tgv_reg   <= chroma_term(yuyv.chroma_red, K_G_V);
            s1_tr_reg    <= chroma_term(yuyv.chroma_red, K_RED);
            s1_addr_reg  <= addr_now;
        end
    end

    // two lanes, one per pixel of the pair
    yb24_pixel_lane u_lane0 (
        .luma    (s1_luma0_reg),
        .term_b  (s1_tb_reg),
        .term_gu (s1_tgu_reg),
        .term_gv (s1_tgv_reg),
        .term_r  (s1_tr_reg),
        .blue    (b0),
        .green   (g0),
        .red     (r0)
    );

    yb24_pixel_lane u_lane1 (
        .luma    (s1_luma1_reg),
        .term_b  (s1_tb_reg),
        .term_gu (s1_tgu_reg),
        .term_gv (s1_tgv_reg),
        .term_r  (s1_tr_reg),
        .blue    (b1),
        .green   (g1),
        .red     (r1)
    );

    // bottom-up index: one 12x13 multiply and an add
    assign row_base   = PROD_W'(s1_addr_reg.row_inv) * PROD_W'(s1_addr_reg.width);
    assign index_full = row_base + PROD_W'(s1_addr_reg.col);

    // merge lanes and index into the output register
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            b0_reg        <= b0;
            g0_reg        <= g0;
            r0_reg        <= r0;
            b1_reg        <= b1;
            g1_reg        <= g1;
            r1_reg        <= r1;
            index_reg     <= index_full[IDX_W-1:0];
            frame_end_reg <= s1_addr_reg.frame_end;
        end
    end

    assign bgr.valid        = out_valid_reg;
    assign bgr.blue_first   = b0_reg;
    assign bgr.green_first  = g0_reg;
    assign bgr.red_first    = r0_reg;
    assign bgr.blue_second  = b1_reg;
    assign bgr.green_second = g1_reg;
    assign bgr.red_second   = r1_reg;
    assign bgr.pixel_index  = index_reg;
    assign bgr.frame_end    = frame_end_reg;

`ifndef NO_ASSERTIONS
    // an accepted request always lands in stage 1
    a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted request lost before stage 1");

    // no accept while both stages are full and output is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> !(s1_valid_reg && out_valid_reg && !bgr.ready))
        else $error("input accepted into a full pipeline");

    // last pair of a frame sits on the first line of the bottom-up buffer
    a_end_top_row: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_addr_reg.frame_end |-> s1_addr_reg.row_inv == '0)
        else $error("frame end off the first buffer line");

    // stage 1 content moves on whenever the output side has room
    a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_ready |=> out_valid_reg)
        else $error("stage 1 request dropped");
`endif

endmodule
